>>> sv/tone_pattern_sequencer_top_macros.svh
// assertion macros for the tone pattern sequencer checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TONE_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define TONE_PATTERN_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define TPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tone pattern sequencer check failed");

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tone pattern sequencer check failed");

`endif

>>> sv/tps_pkg.sv
// shared types, constants and pattern table for the tone pattern sequencer
// no dependencies
`default_nettype none

package tps_pkg;

  localparam int DUTY_BITS  = 10;
  localparam int TIME_BITS  = 32;
  localparam int FREQ_BITS  = 16;
  localparam int CFG_DUTY_W = 10;
  localparam int CFG_DATA_W = 16;
  localparam int DUTY_MAX   = (1 << DUTY_BITS) - 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [DUTY_BITS-1:0] duty_t;
  typedef logic [FREQ_BITS-1:0] freq_t;
  typedef logic [2:0]           pat_t;
  typedef logic [2:0]           pos_t;

  localparam pat_t PAT_NONE    = 3'd0;
  localparam pat_t PAT_WARNING = 3'd6;
  localparam pat_t PAT_ERROR   = 3'd7;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_CUSTOM = 3'd2,
    OP_STOP   = 3'd3,
    OP_ENABLE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_NORMAL_DUTY = 2'd0,
    CFG_STRONG_DUTY = 2'd1,
    CFG_WARN_REPEAT = 2'd2,
    CFG_ERR_REPEAT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_NORMAL = 2'd1,
    LVL_STRONG = 2'd2
  } lvl_e;

  typedef struct packed {
    logic [CFG_DUTY_W-1:0] normal_duty;
    logic [CFG_DUTY_W-1:0] strong_duty;
    logic [15:0]           warning_repeat_ms;
    logic [15:0]           error_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  operation;
    time_t       now_ms;
    logic [3:0]  pattern_id;
    logic [15:0] custom_freq_hz;
    logic [15:0] custom_duty;
    logic [15:0] custom_length_ms;
    logic        enable_value;
  } in_item_t;

  typedef struct packed {
    logic  tone_on;
    freq_t tone_freq_hz;
    duty_t tone_duty;
    logic  busy;
  } res_t;

  typedef struct packed {
    freq_t      freq;
    logic [7:0] dur;
    lvl_e       level;
  } step_t;

  function automatic step_t step_lookup(pat_t pat, pos_t pos);
    step_t s;
    case ({pat, pos})
      {3'd1, 3'd0}: s = '{16'd880,  8'd90,  LVL_NORMAL};
      {3'd1, 3'd1}: s = '{16'd0,    8'd30,  LVL_OFF};
      {3'd1, 3'd2}: s = '{16'd1175, 8'd90,  LVL_NORMAL};
      {3'd1, 3'd3}: s = '{16'd0,    8'd30,  LVL_OFF};
      {3'd1, 3'd4}: s = '{16'd1568, 8'd120, LVL_NORMAL};
      {3'd2, 3'd0}: s = '{16'd1568, 8'd90,  LVL_NORMAL};
      {3'd2, 3'd1}: s = '{16'd0,    8'd30,  LVL_OFF};
      {3'd2, 3'd2}: s = '{16'd1175, 8'd90,  LVL_NORMAL};
      {3'd2, 3'd3}: s = '{16'd0,    8'd30,  LVL_OFF};
      {3'd2, 3'd4}: s = '{16'd880,  8'd120, LVL_NORMAL};
      {3'd3, 3'd0}: s = '{16'd1568, 8'd60,  LVL_NORMAL};
      {3'd3, 3'd1}: s = '{16'd0,    8'd40,  LVL_OFF};
      {3'd3, 3'd2}: s = '{16'd2093, 8'd80,  LVL_NORMAL};
      {3'd4, 3'd0}: s = '{16'd1175, 8'd60,  LVL_NORMAL};
      {3'd5, 3'd0}: s = '{16'd3000, 8'd25,  LVL_STRONG};
      {3'd6, 3'd0}: s = '{16'd1175, 8'd60,  LVL_NORMAL};
      {3'd7, 3'd0}: s = '{16'd880,  8'd70,  LVL_STRONG};
      {3'd7, 3'd1}: s = '{16'd0,    8'd100, LVL_OFF};
      {3'd7, 3'd2}: s = '{16'd880,  8'd70,  LVL_STRONG};
      default:      s = '{16'd0,    8'd0,   LVL_OFF};
    endcase
    return s;
  endfunction

  function automatic pos_t step_count(pat_t pat);
    pos_t c;
    case (pat)
      3'd1, 3'd2:       c = 3'd5;
      3'd3, 3'd7:       c = 3'd3;
      3'd4, 3'd5, 3'd6: c = 3'd1;
      default:          c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] repeat_of(pat_t pat, cfg_t cfg);
    logic [15:0] r;
    r = '0;
    if (pat == PAT_WARNING) r = cfg.warning_repeat_ms;
    if (pat == PAT_ERROR)   r = cfg.error_repeat_ms;
    return r;
  endfunction

  // clamp to the pwm range
  function automatic duty_t sat_duty(logic [15:0] v);
    logic [16:0] w;
    w = {1'b0, v};
    if (w > 17'(DUTY_MAX)) w = 17'(DUTY_MAX);
    return duty_t'(w);
  endfunction

  function automatic duty_t level_duty(lvl_e lvl, cfg_t cfg);
    duty_t d;
    case (lvl)
      LVL_NORMAL: d = sat_duty(16'(cfg.normal_duty));
      LVL_STRONG: d = sat_duty(16'(cfg.strong_duty));
      default:    d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/tps_cfg_regs.sv
// configuration register bank for the tone pattern sequencer
// depends on tps_pkg
`default_nettype none

module tps_cfg_regs import tps_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NORMAL_DUTY: cfg_d.normal_duty       = cfg_data_i[CFG_DUTY_W-1:0];
        CFG_STRONG_DUTY: cfg_d.strong_duty       = cfg_data_i[CFG_DUTY_W-1:0];
        CFG_WARN_REPEAT: cfg_d.warning_repeat_ms = cfg_data_i[15:0];
        CFG_ERR_REPEAT:  cfg_d.error_repeat_ms   = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_duty       <= CFG_DUTY_W'(512);
      cfg_q.strong_duty       <= CFG_DUTY_W'(1023);
      cfg_q.warning_repeat_ms <= 16'd2000;
      cfg_q.error_repeat_ms   <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/tps_core.sv
// playback state and next-state update logic of the tone pattern sequencer
// depends on tps_pkg
`default_nettype none

module tps_core import tps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output res_t          res_o
);

  logic  en_q, en_d;
  pat_t  pat_q, pat_d;
  pos_t  pos_q, pos_d;
  time_t step_end_q, step_end_d;
  time_t start_q, start_d;
  time_t next_cyc_q, next_cyc_d;
  logic  cust_q, cust_d;
  time_t cust_end_q, cust_end_d;
  freq_t freq_q, freq_d;
  duty_t duty_q, duty_d;

  pos_t        cnt, pos_inc, cnt_d;
  logic [15:0] rep, rep_d;
  logic        do_begin;
  pat_t        bpat;
  pos_t        bpos;
  step_t       stp;
  duty_t       stp_duty;
  time_t       now;

  assign now = item_i.now_ms;

  always_comb begin
    en_d       = en_q;
    pat_d      = pat_q;
    pos_d      = pos_q;
    step_end_d = step_end_q;
    start_d    = start_q;
    next_cyc_d = next_cyc_q;
    cust_d     = cust_q;
    cust_end_d = cust_end_q;
    freq_d     = freq_q;
    duty_d     = duty_q;
    do_begin   = 1'b0;
    bpat       = pat_q;
    bpos       = '0;
    cnt        = step_count(pat_q);
    rep        = repeat_of(pat_q, cfg_i);
    pos_inc    = pos_q + 3'd1;

    if (fire_i) begin
      case (op_e'(item_i.operation))
        OP_TICK: begin
          if (!en_q) begin
            freq_d = '0;
            duty_d = '0;
          end else if (cust_q) begin
            if (now >= cust_end_q) begin
              cust_d = 1'b0;
              freq_d = '0;
              duty_d = '0;
            end
          end else if (pat_q != PAT_NONE) begin
            if (pos_q >= cnt) begin
              // waiting for the repeat point
              if (rep == '0) begin
                pat_d  = PAT_NONE;
                freq_d = '0;
                duty_d = '0;
              end else if (now >= next_cyc_q) begin
                start_d  = now;
                pos_d    = '0;
                do_begin = 1'b1;
              end
            end else if (now >= step_end_q) begin
              pos_d = pos_inc;
              if (pos_inc < cnt) begin
                do_begin = 1'b1;
                bpos     = pos_inc;
              end else begin
                freq_d = '0;
                duty_d = '0;
                if (rep == '0) begin
                  pat_d = PAT_NONE;
                end else begin
                  next_cyc_d = start_q + TIME_BITS'(rep);
                end
              end
            end
          end
        end
        OP_START: begin
          if (en_q) begin
            cust_d     = 1'b0;
            pat_d      = item_i.pattern_id[3] ? PAT_NONE : item_i.pattern_id[2:0];
            pos_d      = '0;
            start_d    = now;
            next_cyc_d = '0;
            bpat       = pat_d;
            if (pat_d == PAT_NONE) begin
              freq_d = '0;
              duty_d = '0;
            end else begin
              do_begin = 1'b1;
            end
          end
        end
        OP_CUSTOM: begin
          if (en_q) begin
            if (item_i.custom_freq_hz == '0 || item_i.custom_duty == '0 ||
                item_i.custom_length_ms == '0) begin
              pat_d  = PAT_NONE;
              cust_d = 1'b0;
              freq_d = '0;
              duty_d = '0;
            end else begin
              pat_d      = PAT_NONE;
              cust_d     = 1'b1;
              cust_end_d = now + TIME_BITS'(item_i.custom_length_ms);
              freq_d     = item_i.custom_freq_hz;
              duty_d     = sat_duty(item_i.custom_duty);
            end
          end
        end
        OP_STOP: begin
          pat_d  = PAT_NONE;
          cust_d = 1'b0;
          freq_d = '0;
          duty_d = '0;
        end
        OP_ENABLE: begin
          en_d = item_i.enable_value;
          if (!item_i.enable_value) begin
            pat_d  = PAT_NONE;
            cust_d = 1'b0;
            freq_d = '0;
            duty_d = '0;
          end
        end
        default: ;
      endcase
    end

    // step entry: every path that begins a step has playback enabled
    stp      = step_lookup(bpat, bpos);
    stp_duty = level_duty(stp.level, cfg_i);
    if (do_begin) begin
      step_end_d = now + TIME_BITS'(stp.dur);
      if (stp.freq == '0 || stp.dur == '0 || stp_duty == '0) begin
        freq_d = '0;
        duty_d = '0;
      end else begin
        freq_d = stp.freq;
        duty_d = stp_duty;
      end
    end
  end

  // result from the updated state
  always_comb begin
    cnt_d = step_count(pat_d);
    rep_d = repeat_of(pat_d, cfg_i);
    res_o.tone_on      = (duty_d != '0);
    res_o.tone_freq_hz = (duty_d != '0) ? freq_d : '0;
    res_o.tone_duty    = duty_d;
    res_o.busy         = en_d && (cust_d ||
                         (pat_d != PAT_NONE && (pos_d < cnt_d || rep_d != '0)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b1;
      pat_q      <= PAT_NONE;
      pos_q      <= '0;
      step_end_q <= '0;
      start_q    <= '0;
      next_cyc_q <= '0;
      cust_q     <= 1'b0;
      cust_end_q <= '0;
      freq_q     <= '0;
      duty_q     <= '0;
    end else begin
      en_q       <= en_d;
      pat_q      <= pat_d;
      pos_q      <= pos_d;
      step_end_q <= step_end_d;
      start_q    <= start_d;
      next_cyc_q <= next_cyc_d;
      cust_q     <= cust_d;
      cust_end_q <= cust_end_d;
      freq_q     <= freq_d;
      duty_q     <= duty_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/tone_pattern_sequencer_top.sv
// top level of the tone pattern sequencer: input register, result register
// depends on tps_pkg, tps_cfg_regs and tps_core
`default_nettype none

// Buzzer pattern player. Each input transaction carries the millisecond time
// and one operation (tick, start pattern, custom tone, stop, set enable) and
// yields exactly one result transaction with the drive state (tone_on,
// frequency, duty) and a busy flag. Throughput is one transaction per clock
// while the output side is not stalled: a transaction is captured in the input
// register, the playback state is then updated in a single pass through the
// step table and time compares, and the result lands in the output register
// as the state is written. The output register lets a new transaction
// in while an earlier result waits; in_stall_o rises only when both registers
// are full and out_stall_i is high. Configuration writes are always ready and
// are meant to be issued only while no transaction is in flight.

module tone_pattern_sequencer_top import tps_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            operation_i,
  input  wire logic [TIME_BITS-1:0]  now_ms_i,
  input  wire logic [3:0]            pattern_id_i,
  input  wire logic [15:0]           custom_freq_hz_i,
  input  wire logic [15:0]           custom_duty_i,
  input  wire logic [15:0]           custom_length_ms_i,
  input  wire logic                  enable_value_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       tone_on_o,
  output logic [FREQ_BITS-1:0]       tone_freq_hz_o,
  output logic [DUTY_BITS-1:0]       tone_duty_o,
  output logic                       busy_res_o,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic     in_vld_q, in_vld_d;
  in_item_t item_q;
  logic     out_vld_q, out_vld_d;
  res_t     res_q;
  res_t     res_next;
  cfg_t     cfg;
  logic     advance;
  logic     fire;
  logic     take;

  // output register can load when empty or being drained this cycle
  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_stall_o ? in_vld_q : in_valid_i;
  assign out_vld_d = advance ? fire : out_vld_q;

  tps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // state is updated exactly once per transaction, when it moves on
  tps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.operation        <= operation_i;
      item_q.now_ms           <= now_ms_i;
      item_q.pattern_id       <= pattern_id_i;
      item_q.custom_freq_hz   <= custom_freq_hz_i;
      item_q.custom_duty      <= custom_duty_i;
      item_q.custom_length_ms <= custom_length_ms_i;
      item_q.enable_value     <= enable_value_i;
    end
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign tone_on_o      = res_q.tone_on;
  assign tone_freq_hz_o = res_q.tone_freq_hz;
  assign tone_duty_o    = res_q.tone_duty;
  assign busy_res_o     = res_q.busy;

endmodule

`default_nettype wire

>>> sv/tps_checker.sv
// port-level checks for the tone pattern sequencer, bound to the top level
// depends on tps_pkg and tone_pattern_sequencer_top_macros.svh
`default_nettype none
`include "tone_pattern_sequencer_top_macros.svh"

module tps_checker import tps_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic                 tone_on_o,
  input wire logic [FREQ_BITS-1:0] tone_freq_hz_o,
  input wire logic [DUTY_BITS-1:0] tone_duty_o
);

  // a stalled result stays offered
  `TPS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // input backpressure only when a result is waiting
  `TPS_ASSERT_IMPL(a_stall_full, in_stall_o, out_valid_o && out_stall_i)
  // silent results carry no frequency or duty
  `TPS_ASSERT_IMPL(a_off_quiet, out_valid_o && !tone_on_o, tone_freq_hz_o == '0 && tone_duty_o == '0)
  // a driven result always has duty
  `TPS_ASSERT_IMPL(a_on_duty, out_valid_o && tone_on_o, tone_duty_o != '0 && tone_freq_hz_o != '0)

endmodule

bind tone_pattern_sequencer_top tps_checker u_tps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .tone_on_o      (tone_on_o),
  .tone_freq_hz_o (tone_freq_hz_o),
  .tone_duty_o    (tone_duty_o)
);

`default_nettype wire

>>> bench/tone_pattern_sequencer_top_test.sv
// self-checking bench for tone_pattern_sequencer_top: directed table, then random phases
// depends on tps_pkg and the sequencer rtl, reads no files
`timescale 1ns / 1ps

module tone_pattern_sequencer_top_test;
  import tps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 60;
  // operation codes the block has no meaning for
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;
  localparam res_t QUIET = '0;

  // one step of a tone pattern as the bench sees it
  typedef struct packed {
    logic [15:0] hz;
    logic [7:0]  ms;
    lvl_e        lvl;
  } note_t;

  // one row of the directed table: either a register write or a transaction
  typedef struct packed {
    logic     is_cfg;
    cfg_idx_e reg_sel;
    logic [15:0] reg_val;
    in_item_t item;
    logic     typed;
    res_t     want;
  } drill_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            operation_i = '0;
  logic [TIME_BITS-1:0]  now_ms_i = '0;
  logic [3:0]            pattern_id_i = '0;
  logic [15:0]           custom_freq_hz_i = '0;
  logic [15:0]           custom_duty_i = '0;
  logic [15:0]           custom_length_ms_i = '0;
  logic                  enable_value_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  tone_on_o;
  logic [FREQ_BITS-1:0]  tone_freq_hz_o;
  logic [DUTY_BITS-1:0]  tone_duty_o;
  logic                  busy_res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tone_pattern_sequencer_top u_top (.*);

  // shadow of the player: settings
  logic [9:0]  duty_normal, duty_strong;
  logic [15:0] warn_rep, err_rep;
  // shadow of the player: playback state
  logic        sim_on, custom_on;
  pat_t        pat_cur;
  pos_t        pos_cur;
  logic [31:0] step_end_ms, pat_start_ms, next_cycle_ms, custom_end_ms;
  logic [15:0] drv_hz;
  logic [9:0]  drv_duty;

  res_t        pending_drive_q[$];
  logic [31:0] ms_clock;
  bit          calm = 1'b0;
  int unsigned failures = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still outstanding", $time, pending_drive_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic note_t note_at(pat_t pat, pos_t pos);
    note_t n;
    n = '{16'd0, 8'd0, LVL_OFF};
    case (pat)
      // rising and falling five-step chimes share their shape
      3'd1, 3'd2: begin
        case (pos)
          3'd0: n = '{(pat == 3'd1) ? 16'd880 : 16'd1568, 8'd90, LVL_NORMAL};
          3'd1, 3'd3: n = '{16'd0, 8'd30, LVL_OFF};
          3'd2: n = '{16'd1175, 8'd90, LVL_NORMAL};
          3'd4: n = '{(pat == 3'd1) ? 16'd1568 : 16'd880, 8'd120, LVL_NORMAL};
          default: ;
        endcase
      end
      3'd3: begin
        case (pos)
          3'd0: n = '{16'd1568, 8'd60, LVL_NORMAL};
          3'd1: n = '{16'd0, 8'd40, LVL_OFF};
          3'd2: n = '{16'd2093, 8'd80, LVL_NORMAL};
          default: ;
        endcase
      end
      3'd4, PAT_WARNING: begin
        if (pos == 3'd0) n = '{16'd1175, 8'd60, LVL_NORMAL};
      end
      3'd5: begin
        if (pos == 3'd0) n = '{16'd3000, 8'd25, LVL_STRONG};
      end
      PAT_ERROR: begin
        case (pos)
          3'd0, 3'd2: n = '{16'd880, 8'd70, LVL_STRONG};
          3'd1: n = '{16'd0, 8'd100, LVL_OFF};
          default: ;
        endcase
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic pos_t notes_in(pat_t pat);
    case (pat)
      3'd1, 3'd2: return 3'd5;
      3'd3, PAT_ERROR: return 3'd3;
      3'd4, 3'd5, PAT_WARNING: return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [15:0] repeat_ms(pat_t pat);
    if (pat == PAT_WARNING) return warn_rep;
    if (pat == PAT_ERROR) return err_rep;
    return '0;
  endfunction

  function automatic void hush();
    pat_cur   = PAT_NONE;
    custom_on = 1'b0;
    drv_hz    = '0;
    drv_duty  = '0;
  endfunction

  function automatic void begin_note(logic [31:0] now);
    note_t      n;
    logic [9:0] d;
    n = note_at(pat_cur, pos_cur);
    case (n.lvl)
      LVL_NORMAL: d = duty_normal;
      LVL_STRONG: d = duty_strong;
      default:    d = '0;
    endcase
    step_end_ms = now + 32'(n.ms);
    // a silent step keeps its time slot but drives nothing
    if (!sim_on || n.hz == '0 || n.ms == '0 || d == '0) begin
      drv_hz   = '0;
      drv_duty = '0;
    end else begin
      drv_hz   = n.hz;
      drv_duty = d;
    end
  endfunction

  function automatic void reset_player();
    duty_normal   = 10'd512;
    duty_strong   = 10'd1023;
    warn_rep      = 16'd2000;
    err_rep       = 16'd1000;
    sim_on        = 1'b1;
    pat_cur       = PAT_NONE;
    pos_cur       = '0;
    step_end_ms   = '0;
    pat_start_ms  = '0;
    next_cycle_ms = '0;
    custom_on     = 1'b0;
    custom_end_ms = '0;
    drv_hz        = '0;
    drv_duty      = '0;
  endfunction

  // advances the shadow player by one transaction and returns its drive state
  function automatic res_t predict_drive(in_item_t it);
    res_t        r;
    logic [31:0] now;
    pos_t        count;
    logic [15:0] rep;
    now = it.now_ms;
    case (it.operation)
      OP_TICK: begin
        if (!sim_on) begin
          drv_hz   = '0;
          drv_duty = '0;
        end else if (custom_on) begin
          if (now >= custom_end_ms) begin
            custom_on = 1'b0;
            drv_hz    = '0;
            drv_duty  = '0;
          end
        end else if (pat_cur != PAT_NONE) begin
          count = notes_in(pat_cur);
          rep   = repeat_ms(pat_cur);
          if (pos_cur >= count) begin
            // waiting for the restart; a zeroed interval ends the pattern
            if (rep == '0) begin
              pat_cur  = PAT_NONE;
              drv_hz   = '0;
              drv_duty = '0;
            end else if (now >= next_cycle_ms) begin
              pat_start_ms = now;
              pos_cur      = '0;
              begin_note(now);
            end
          end else if (now >= step_end_ms) begin
            pos_cur++;
            if (pos_cur < count) begin
              begin_note(now);
            end else begin
              drv_hz   = '0;
              drv_duty = '0;
              if (rep == '0) pat_cur = PAT_NONE;
              else next_cycle_ms = pat_start_ms + 32'(rep);
            end
          end
        end
      end
      OP_START: begin
        if (sim_on) begin
          custom_on     = 1'b0;
          pat_cur       = it.pattern_id[3] ? PAT_NONE : pat_t'(it.pattern_id[2:0]);
          pos_cur       = '0;
          pat_start_ms  = now;
          next_cycle_ms = '0;
          if (pat_cur == PAT_NONE) begin
            drv_hz   = '0;
            drv_duty = '0;
          end else begin
            begin_note(now);
          end
        end
      end
      OP_CUSTOM: begin
        if (sim_on) begin
          if (it.custom_freq_hz == '0 || it.custom_duty == '0 || it.custom_length_ms == '0) begin
            hush();
          end else begin
            pat_cur       = PAT_NONE;
            custom_on     = 1'b1;
            custom_end_ms = now + 32'(it.custom_length_ms);
            drv_hz        = it.custom_freq_hz;
            drv_duty      = (it.custom_duty > 16'(DUTY_MAX)) ? '1 : it.custom_duty[9:0];
          end
        end
      end
      OP_STOP: hush();
      OP_ENABLE: begin
        sim_on = it.enable_value;
        if (!sim_on) hush();
      end
      default: ;
    endcase
    r.busy = sim_on && (custom_on || (pat_cur != PAT_NONE &&
             (pos_cur < notes_in(pat_cur) || repeat_ms(pat_cur) != '0)));
    r.tone_on      = (drv_duty != '0);
    r.tone_freq_hz = r.tone_on ? drv_hz : '0;
    r.tone_duty    = r.tone_on ? drv_duty : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (failures < 40)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // every result transaction is matched against the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, actual on=%0d freq=%0d",
                 $time, tone_on_o, tone_freq_hz_o);
        failures++;
      end else begin
        want = pending_drive_q.pop_front();
        cmp_field("tone_on", 16'(want.tone_on), 16'(tone_on_o));
        cmp_field("tone_freq_hz", want.tone_freq_hz, tone_freq_hz_o);
        cmp_field("tone_duty", 16'(want.tone_duty), 16'(tone_duty_o));
        cmp_field("busy_res", 16'(want.busy), 16'(busy_res_o));
        results_checked++;
      end
    end
  end

  // result side back-pressure: random stall bursts until the calm tail
  initial begin
    @(posedge rst_ni);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic in_item_t mk_item(logic [2:0] op, logic [31:0] t, logic [3:0] pid,
                                       logic [15:0] hz, logic [15:0] duty,
                                       logic [15:0] len, logic en);
    in_item_t it;
    it.operation        = op;
    it.now_ms           = t;
    it.pattern_id       = pid;
    it.custom_freq_hz   = hz;
    it.custom_duty      = duty;
    it.custom_length_ms = len;
    it.enable_value     = en;
    return it;
  endfunction

  function automatic drill_row_t play(in_item_t it, logic typed, res_t want);
    drill_row_t row;
    row        = '0;
    row.item   = it;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  function automatic drill_row_t setting(cfg_idx_e sel, logic [15:0] val);
    drill_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // mostly well-formed playback (starts followed by advancing ticks), some noise
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.pattern_id       = 4'($urandom);
    it.custom_freq_hz   = 16'($urandom);
    it.custom_duty      = 16'($urandom);
    it.custom_length_ms = 16'($urandom);
    it.enable_value     = 1'($urandom);
    pick = $urandom_range(0, 99);
    // rare jump anywhere in time, backwards included
    if (pick < 3) ms_clock = $urandom;
    if (pick < 60) begin
      it.operation = OP_TICK;
      ms_clock     = ms_clock + $urandom_range(0, 130);
    end else begin
      ms_clock = ms_clock + $urandom_range(0, 3);
      if (pick < 75) begin
        it.operation = OP_START;
        if ($urandom_range(0, 9) != 0) it.pattern_id = 4'($urandom_range(1, 7));
      end else if (pick < 84) begin
        it.operation        = OP_CUSTOM;
        it.custom_freq_hz   = 16'($urandom_range(1, 4000));
        it.custom_duty      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(1, 1023));
        it.custom_length_ms = 16'($urandom_range(1, 400));
        case ($urandom_range(0, 7))
          0: it.custom_freq_hz = '0;
          1: it.custom_duty = '0;
          2: it.custom_length_ms = '0;
          3: it.custom_freq_hz = 16'($urandom);
          default: ;
        endcase
      end else if (pick < 89) begin
        it.operation = OP_STOP;
      end else if (pick < 95) begin
        it.operation    = OP_ENABLE;
        it.enable_value = ($urandom_range(0, 3) != 0);
      end else begin
        it.operation = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
    end
    it.now_ms = ms_clock;
    return it;
  endfunction

  function automatic logic [15:0] pick_setting(logic [15:0] top);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return top;
      2: return 16'($urandom_range(1, 300));
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  // one input transaction; the shadow player advances at the accepting edge
  task automatic send_item(in_item_t it, logic typed, res_t want);
    res_t guess;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    operation_i        <= it.operation;
    now_ms_i           <= it.now_ms;
    pattern_id_i       <= it.pattern_id;
    custom_freq_hz_i   <= it.custom_freq_hz;
    custom_duty_i      <= it.custom_duty;
    custom_length_ms_i <= it.custom_length_ms;
    enable_value_i     <= it.enable_value;
    do @(posedge clk_i); while (in_stall_o);
    guess = predict_drive(it);
    pending_drive_q.push_back(typed ? want : guess);
    items_sent++;
  endtask

  // hold the input side until every predicted result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // caller drops cfg_valid_i after its last write
  task automatic write_reg(cfg_idx_e sel, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (sel)
      CFG_NORMAL_DUTY: duty_normal = val[9:0];
      CFG_STRONG_DUTY: duty_strong = val[9:0];
      CFG_WARN_REPEAT: warn_rep = val;
      default:         err_rep = val;
    endcase
    cfg_writes++;
  endtask

  initial begin
    drill_row_t drill[$];
    in_item_t   it;

    reset_player();
    ms_clock = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: idle behavior, each operation, extremes and corner cases
    drill.push_back(play(mk_item(OP_TICK, 32'd0, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, QUIET));
    drill.push_back(play(mk_item(OP_RESERVED_LO, 32'd0, 4'd3, 16'd9, 16'd9, 16'd9, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_RESERVED_HI, 32'd0, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_START, 32'd100, 4'd1, 16'd0, 16'd0, 16'd0, 1'b1),
                         1'b1, res_t'{1'b1, 16'd880, 10'd512, 1'b1}));
    drill.push_back(play(mk_item(OP_TICK, 32'd189, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, QUIET));
    // second step of the chime is a silent gap that still takes its time
    drill.push_back(play(mk_item(OP_TICK, 32'd190, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, QUIET));
    // custom tone with every operand at its top, duty clamps to the pwm range
    drill.push_back(play(mk_item(OP_CUSTOM, 32'd200, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0),
                         1'b1, res_t'{1'b1, 16'hFFFF, 10'h3FF, 1'b1}));
    drill.push_back(play(mk_item(OP_TICK, 32'd65735, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_START, 32'd70000, 4'd7, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, res_t'{1'b1, 16'd880, 10'd1023, 1'b1}));
    // zero length custom tone behaves as stop
    drill.push_back(play(mk_item(OP_CUSTOM, 32'd70001, 4'd0, 16'd440, 16'd300, 16'd0, 1'b0),
                         1'b1, QUIET));
    // out of table pattern id means none
    drill.push_back(play(mk_item(OP_START, 32'd70002, 4'd15, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_START, 32'd70003, 4'd3, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, QUIET));
    drill.push_back(play(mk_item(OP_STOP, 32'd70004, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, QUIET));
    // disabled: starts and custom tones are dropped, stop and tick keep it silent
    drill.push_back(play(mk_item(OP_ENABLE, 32'd70010, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_START, 32'd70011, 4'd5, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_CUSTOM, 32'd70012, 4'd0, 16'd1000, 16'd500, 16'd100, 1'b0),
                         1'b1, QUIET));
    drill.push_back(play(mk_item(OP_TICK, 32'd70013, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, QUIET));
    drill.push_back(play(mk_item(OP_STOP, 32'd70014, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, QUIET));
    drill.push_back(play(mk_item(OP_ENABLE, 32'd70020, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1),
                         1'b1, QUIET));
    // warning pattern waits for its restart, then the interval is zeroed under it
    drill.push_back(play(mk_item(OP_START, 32'd80000, 4'd6, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, QUIET));
    drill.push_back(play(mk_item(OP_TICK, 32'd80060, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, QUIET));
    drill.push_back(setting(CFG_WARN_REPEAT, 16'd0));
    drill.push_back(play(mk_item(OP_TICK, 32'd80061, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1, QUIET));
    // zero strong duty turns the step silent while the pattern stays busy
    drill.push_back(setting(CFG_STRONG_DUTY, 16'd0));
    drill.push_back(play(mk_item(OP_START, 32'd90000, 4'd5, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, QUIET));
    drill.push_back(setting(CFG_STRONG_DUTY, 16'd1023));
    // step end time wraps past the top of the millisecond counter
    drill.push_back(play(mk_item(OP_START, 32'hFFFF_FFF0, 4'd5, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b1, res_t'{1'b1, 16'd3000, 10'd1023, 1'b1}));
    drill.push_back(play(mk_item(OP_TICK, 32'hFFFF_FFFF, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                         1'b0, QUIET));
    drill.push_back(play(mk_item(OP_START, 32'd0, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1), 1'b1, QUIET));

    foreach (drill[i]) begin
      if (drill[i].is_cfg) begin
        settle();
        write_reg(drill[i].reg_sel, drill[i].reg_val);
        cfg_valid_i <= 1'b0;
      end else begin
        send_item(drill[i].item, drill[i].typed, drill[i].want);
      end
    end

    // random phases: reset values, all at top, all zero, then mixed settings;
    // the drain before each phase is also the sender-side pause
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(CFG_NORMAL_DUTY, 16'd512);
          write_reg(CFG_STRONG_DUTY, 16'd1023);
          write_reg(CFG_WARN_REPEAT, 16'd2000);
          write_reg(CFG_ERR_REPEAT, 16'd1000);
        end
        1: begin
          write_reg(CFG_NORMAL_DUTY, 16'd1023);
          write_reg(CFG_STRONG_DUTY, 16'd1023);
          write_reg(CFG_WARN_REPEAT, 16'hFFFF);
          write_reg(CFG_ERR_REPEAT, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_NORMAL_DUTY, 16'd0);
          write_reg(CFG_STRONG_DUTY, 16'd0);
          write_reg(CFG_WARN_REPEAT, 16'd0);
          write_reg(CFG_ERR_REPEAT, 16'd0);
        end
        default: begin
          write_reg(CFG_NORMAL_DUTY, pick_setting(16'd1023));
          write_reg(CFG_STRONG_DUTY, pick_setting(16'd1023));
          write_reg(CFG_WARN_REPEAT, pick_setting(16'hFFFF));
          write_reg(CFG_ERR_REPEAT, pick_setting(16'hFFFF));
        end
      endcase
      cfg_valid_i <= 1'b0;
      // one phase runs right below the counter top to cross the wrap
      if (phase == 4) ms_clock = 32'hFFFF_F000;
      // the last phase runs with no idling on either side
      if (phase == PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) begin
        it = random_item();
        send_item(it, 1'b0, QUIET);
      end
    end

    settle();
    $display("covered %0d transactions over %0d setting phases, %0d register writes",
             items_sent, PHASES + 1, cfg_writes);
    $display("checked %0d results field by field, %0d field mismatches",
             results_checked, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/tps_pkg.sv
sv/tps_cfg_regs.sv
sv/tps_core.sv
sv/tone_pattern_sequencer_top.sv
sv/tps_checker.sv
bench/tone_pattern_sequencer_top_test.sv
